// ----- src/bgrs_pkg.sv -----
// ----------------------------------------------------------------------------
// bgrs_pkg
// Types and constants shared by the bitmap glyph row scaler: item beats,
// clamped configuration and the control word that rides the pipeline.
// ----------------------------------------------------------------------------
package bgrs_pkg;

  // item modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE_FACTOR = 2'd2;
  localparam logic [1:0] REG_GLYPH_COUNT  = 2'd3;

  // reset values
  localparam logic [4:0] RST_GLYPH_WIDTH  = 5'd8;
  localparam logic [5:0] RST_GLYPH_HEIGHT = 6'd16;
  localparam logic [2:0] RST_SCALE_FACTOR = 3'd1;
  localparam logic [9:0] RST_GLYPH_COUNT  = 10'd256;

  // glyph used for codes beyond the font
  localparam logic [8:0] QUESTION_GLYPH = 9'd63;

  typedef struct packed {
    logic        mode;
    logic [14:0] font_address;
    logic [7:0]  font_byte;
    logic [15:0] glyph_code;
    logic [6:0]  out_row;
    logic        bold;
    logic        underline;
  } in_item_t;

  typedef struct packed {
    logic [63:0] pixel_row;
    logic        row_valid;
    logic        substituted;
  } out_item_t;

  // configuration after saturation into legal ranges
  typedef struct packed {
    logic [4:0] w;   // 1..16
    logic [5:0] h;   // 1..32
    logic [2:0] s;   // 1..4
    logic [9:0] n;   // 1..512
  } cfg_t;

  // per-beat control carried down the pipeline
  typedef struct packed {
    logic        vld;
    logic        wr;
    logic        rd;
    logic [14:0] waddr;
    logic [7:0]  wbyte;
    logic        subst;
    logic        bold;
    logic        under;
    logic        last;
  } ctl_t;

endpackage

// ----- src/bgrs_ram.sv -----
// ----------------------------------------------------------------------------
// bgrs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bgrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bgrs_addr.sv -----
// ----------------------------------------------------------------------------
// bgrs_addr
// Front of the pipeline: glyph substitution and source row, glyph base
// product, row base address, and wrap of both byte addresses into the font.
// ----------------------------------------------------------------------------
module bgrs_addr
  import bgrs_pkg::*;
#(
  parameter int FONT_BYTES = 32768
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  in_item_t                      cmd,
  input  cfg_t                          cfg,
  output ctl_t                          ctl_d,
  output logic [$clog2(FONT_BYTES)-1:0] addr0_d,
  output logic [$clog2(FONT_BYTES)-1:0] addr1_d
);

  localparam int AW = $clog2(FONT_BYTES);

  // stage a: substitution, source row, range check
  ctl_t        ctl_a, ctl_a_next;
  logic [8:0]  code_a, code_a_next;
  logic [4:0]  srow_a;
  logic [7:0]  rows_total;
  logic [14:0] mul3;
  logic [6:0]  srow_full;
  logic        in_range;
  logic        code_ok;

  always_comb begin
    rows_total = 8'(cfg.h) * 8'(cfg.s);
    in_range   = {1'b0, cmd.out_row} < rows_total;
    code_ok    = cmd.glyph_code < 16'(cfg.n);
    mul3       = 15'(cmd.out_row) * 15'd171;
    case (cfg.s)
      3'd1:    srow_full = cmd.out_row;
      3'd2:    srow_full = cmd.out_row >> 1;
      3'd3:    srow_full = 7'(mul3 >> 9);
      default: srow_full = cmd.out_row >> 2;
    endcase
    ctl_a_next.vld   = in_valid;
    ctl_a_next.wr    = (cmd.mode == MODE_WRITE) &&
                       ({2'b00, cmd.font_address} < 17'(FONT_BYTES));
    ctl_a_next.rd    = (cmd.mode == MODE_RENDER) && in_range;
    ctl_a_next.waddr = cmd.font_address;
    ctl_a_next.wbyte = cmd.font_byte;
    ctl_a_next.subst = (cmd.mode == MODE_RENDER) && in_range && !code_ok;
    ctl_a_next.bold  = cmd.bold;
    ctl_a_next.under = cmd.underline;
    ctl_a_next.last  = srow_full == 7'(cfg.h - 6'd1);
    code_a_next      = code_ok ? cmd.glyph_code[8:0] : QUESTION_GLYPH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.vld <= 1'b0;
    end else begin
      ctl_a <= ctl_a_next;
    end
    code_a <= code_a_next;
    srow_a <= srow_full[4:0];
  end

  // stage b: glyph base = code * height
  ctl_t        ctl_b;
  logic [14:0] prod_b;
  logic [4:0]  srow_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b.vld <= 1'b0;
    end else begin
      ctl_b <= ctl_a;
    end
    prod_b <= 15'(code_a) * 15'(cfg.h);
    srow_b <= srow_a;
  end

  // stage c: row base in bytes, and the following byte
  ctl_t        ctl_c;
  logic [14:0] base0_c, base1_c;
  logic [14:0] sum_b, base_b;

  always_comb begin
    sum_b  = prod_b + 15'(srow_b);
    base_b = (cfg.w > 5'd8) ? {sum_b[13:0], 1'b0} : sum_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c.vld <= 1'b0;
    end else begin
      ctl_c <= ctl_b;
    end
    base0_c <= base_b;
    base1_c <= base_b + 15'd1;
  end

  // stage d: wrap both addresses into the font size
  logic [22:0] r0, r1;

  always_comb begin
    r0 = 23'(base0_c);
    r1 = 23'(base1_c);
    for (int k = 6; k >= 0; k--) begin
      if (r0 >= 23'(FONT_BYTES << k)) begin
        r0 = r0 - 23'(FONT_BYTES << k);
      end
      if (r1 >= 23'(FONT_BYTES << k)) begin
        r1 = r1 - 23'(FONT_BYTES << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d.vld <= 1'b0;
    end else begin
      ctl_d <= ctl_c;
    end
    addr0_d <= r0[AW-1:0];
    addr1_d <= r1[AW-1:0];
  end

endmodule

// ----- src/bgrs_row.sv -----
// ----------------------------------------------------------------------------
// bgrs_row
// Back of the pipeline: lines up control with font read data, forms the
// styled source row and replicates each column into the output mask.
// ----------------------------------------------------------------------------
module bgrs_row
  import bgrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  ctl_t      ctl_d,
  input  logic [7:0] byte0,
  input  logic [7:0] byte1,
  output logic      done,
  output out_item_t result
);

  // stage e: read data arrives with this beat
  ctl_t ctl_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_e.vld <= 1'b0;
    end else begin
      ctl_e <= ctl_d;
    end
  end

  // stage f: left-aligned row, styled, then reversed so column c is bit c
  ctl_t        ctl_f;
  logic [15:0] rev_f;
  logic [15:0] raw, mask_w, la, rev;

  always_comb begin
    raw    = (cfg.w > 5'd8) ? {byte0, byte1} : {byte0, 8'h00};
    mask_w = ~(16'hffff >> cfg.w);
    la     = raw & mask_w;
    if (ctl_e.bold) begin
      la = (la | (la >> 1)) & mask_w;
    end
    if (ctl_e.under && ctl_e.last) begin
      la = mask_w;
    end
    for (int c = 0; c < 16; c++) begin
      rev[c] = la[15-c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_f.vld <= 1'b0;
    end else begin
      ctl_f <= ctl_e;
    end
    rev_f <= rev;
  end

  // stage g: column replication
  logic [63:0] pix;

  always_comb begin
    pix = '0;
    case (cfg.s)
      3'd1: begin
        for (int c = 0; c < 16; c++) begin
          pix[c] = rev_f[c];
        end
      end
      3'd2: begin
        for (int c = 0; c < 16; c++) begin
          for (int r = 0; r < 2; r++) begin
            pix[c*2+r] = rev_f[c];
          end
        end
      end
      3'd3: begin
        for (int c = 0; c < 16; c++) begin
          for (int r = 0; r < 3; r++) begin
            pix[c*3+r] = rev_f[c];
          end
        end
      end
      default: begin
        for (int c = 0; c < 16; c++) begin
          for (int r = 0; r < 4; r++) begin
            pix[c*4+r] = rev_f[c];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_f.vld;
    end
    result.pixel_row   <= ctl_f.rd ? pix : 64'd0;
    result.row_valid   <= ctl_f.rd;
    result.substituted <= ctl_f.subst;
  end

endmodule

// ----- src/bitmap_glyph_row_scaler.sv -----
// ----------------------------------------------------------------------------
// bitmap_glyph_row_scaler
// Font byte store and scaled glyph row renderer with an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   cmd is taken at each rising edge with start high and busy low; busy is
//   never raised, so a new beat may be presented every cycle.
//   A write beat (mode 0) stores font_byte at font_address; a render beat
//   (mode 1) returns one scaled pixel row of a glyph.
//   Every beat gives exactly one result: done rises with the result once the
//   beat has passed stages a to d of bgrs_addr and e and f of bgrs_row.
//   Throughput is one beat per cycle; the font is read through two copies
//   of a byte RAM so both bytes of a wide row come in one read.
//   Results are not held: the receiver must take each one as it shows.
//   Writes reach the RAM in the same stage as render reads, so beats see
//   font data in the order they were issued.
//   Registers (glyph_width, glyph_height, scale_factor, glyph_count) sit at
//   byte offsets 0, 4, 8, 12; the user must change them only with the
//   pipeline empty, not enforced by the block. Reset empties the pipeline
//   and loads register defaults; font contents are undefined until written.
// ----------------------------------------------------------------------------
module bitmap_glyph_row_scaler
  import bgrs_pkg::*;
#(
  parameter int FONT_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  in_item_t    cmd,
  output logic        busy,
  output logic        done,
  output out_item_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(FONT_BYTES);

  // register file
  logic [4:0] glyph_width;
  logic [5:0] glyph_height;
  logic [2:0] scale_factor;
  logic [9:0] glyph_count;
  logic       reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= RST_GLYPH_WIDTH;
      glyph_height <= RST_GLYPH_HEIGHT;
      scale_factor <= RST_SCALE_FACTOR;
      glyph_count  <= RST_GLYPH_COUNT;
    end else if (reg_wr) begin
      case (paddr[3:2])
        REG_GLYPH_WIDTH:  glyph_width  <= pwdata[4:0];
        REG_GLYPH_HEIGHT: glyph_height <= pwdata[5:0];
        REG_SCALE_FACTOR: scale_factor <= pwdata[2:0];
        REG_GLYPH_COUNT:  glyph_count  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GLYPH_WIDTH:  prdata = 32'(glyph_width);
      REG_GLYPH_HEIGHT: prdata = 32'(glyph_height);
      REG_SCALE_FACTOR: prdata = 32'(scale_factor);
      REG_GLYPH_COUNT:  prdata = 32'(glyph_count);
      default:          prdata = 32'd0;
    endcase
  end

  // saturate registers into their legal ranges
  cfg_t cfg_c;

  always_comb begin
    cfg_c.w = (glyph_width == 5'd0) ? 5'd1 :
              (glyph_width > 5'd16) ? 5'd16 : glyph_width;
    cfg_c.h = (glyph_height == 6'd0) ? 6'd1 :
              (glyph_height > 6'd32) ? 6'd32 : glyph_height;
    cfg_c.s = (scale_factor == 3'd0) ? 3'd1 :
              (scale_factor > 3'd4) ? 3'd4 : scale_factor;
    cfg_c.n = (glyph_count == 10'd0) ? 10'd1 :
              (glyph_count > 10'd512) ? 10'd512 : glyph_count;
  end

  assign busy = 1'b0;

  ctl_t          ctl_d;
  logic [AW-1:0] addr0_d, addr1_d;
  logic [AW-1:0] waddr;
  logic          ram_we;
  logic [7:0]    byte0, byte1;

  bgrs_addr #(
    .FONT_BYTES(FONT_BYTES)
  ) u_addr (
    .clk     (clk),
    .rst     (rst),
    .in_valid(start && !busy),
    .cmd     (cmd),
    .cfg     (cfg_c),
    .ctl_d   (ctl_d),
    .addr0_d (addr0_d),
    .addr1_d (addr1_d)
  );

  assign ram_we = ctl_d.vld && ctl_d.wr;
  assign waddr  = AW'(ctl_d.waddr);

  // two copies of the font, one per byte of a row
  bgrs_ram #(
    .WIDTH(8),
    .DEPTH(FONT_BYTES)
  ) u_font_ram_a (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(ctl_d.wbyte),
    .raddr(addr0_d),
    .rdata(byte0)
  );

  bgrs_ram #(
    .WIDTH(8),
    .DEPTH(FONT_BYTES)
  ) u_font_ram_b (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(ctl_d.wbyte),
    .raddr(addr1_d),
    .rdata(byte1)
  );

  bgrs_row u_row (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_c),
    .ctl_d (ctl_d),
    .byte0 (byte0),
    .byte1 (byte1),
    .done  (done),
    .result(result)
  );

`ifndef SYNTH
  a_done_has_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 7))
    else $error("result strobe without an accepted beat");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 done)
    else $error("accepted beat produced no result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && !result.row_valid) |-> (result.pixel_row == 64'd0 && !result.substituted))
    else $error("non-row result carries data");

  a_unused_columns: assert property (@(posedge clk) disable iff (rst)
    (done && result.row_valid) |->
      ((result.pixel_row >> (7'(cfg_c.w) * 7'(cfg_c.s))) == 64'd0))
    else $error("pixels lit beyond scaled glyph width");
`endif

endmodule

// ----- tb/tb_bitmap_glyph_row_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_glyph_row_scaler
// Self-checking bench for the glyph row scaler. It loads font bytes, renders
// scaled rows under several register settings, including saturated ones, and
// compares every result beat against an in-bench row predictor.
// ----------------------------------------------------------------------------
module tb_bitmap_glyph_row_scaler;
  import bgrs_pkg::*;

  localparam int FONT_BYTES    = 32768;
  localparam int CLK_HALF      = 10;
  localparam int DRAIN_CYCLES  = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_BEATS   = 140;
  localparam int RANDOM_PHASES = 10;

  logic        clk;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  in_item_t    cmd     = '0;
  logic        busy;
  logic        done;
  out_item_t   result;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  bitmap_glyph_row_scaler #(
    .FONT_BYTES(FONT_BYTES)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // register values as written; saturated where they are used
  logic [4:0] glyph_width_reg  = RST_GLYPH_WIDTH;
  logic [5:0] glyph_height_reg = RST_GLYPH_HEIGHT;
  logic [2:0] scale_reg        = RST_SCALE_FACTOR;
  logic [9:0] glyph_count_reg  = RST_GLYPH_COUNT;

  bit [7:0]  font_mem     [FONT_BYTES];
  bit        font_written [FONT_BYTES];
  out_item_t expected_rows[$];

  int unsigned error_count      = 0;
  int unsigned beats_sent       = 0;
  int unsigned write_acks       = 0;
  int unsigned rows_rendered    = 0;
  int unsigned rows_substituted = 0;
  int unsigned rows_blank       = 0;
  int unsigned settings_applied = 0;
  int unsigned idle_cycles      = 0;
  bit          no_gaps          = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    return clamp_u(glyph_width_reg, 1, 16);
  endfunction

  function automatic int unsigned eff_height();
    return clamp_u(glyph_height_reg, 1, 32);
  endfunction

  function automatic int unsigned eff_scale();
    return clamp_u(scale_reg, 1, 4);
  endfunction

  function automatic int unsigned eff_count();
    return clamp_u(glyph_count_reg, 1, 512);
  endfunction

  // font bytes a render beat reads; returns 0 when the row is out of the glyph
  function automatic bit locate_row(input in_item_t it, output int unsigned addr,
                                    output int unsigned nbytes, output bit subst);
    int unsigned h;
    int unsigned s;
    int unsigned code;
    h      = eff_height();
    s      = eff_scale();
    code   = it.glyph_code;
    subst  = 1'b0;
    nbytes = (eff_width() + 7) / 8;
    addr   = 0;
    if (it.out_row >= h * s) return 1'b0;
    if (code >= eff_count()) begin
      code  = QUESTION_GLYPH;
      subst = 1'b1;
    end
    addr = (code * h + it.out_row / s) * nbytes;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_beat(input in_item_t it);
    out_item_t   r;
    int unsigned addr;
    int unsigned nbytes;
    int unsigned w;
    int unsigned s;
    int unsigned srow;
    int unsigned row;
    int unsigned i;
    bit          subst;
    r = '0;
    if (it.mode == MODE_WRITE) begin
      font_mem[it.font_address]     = it.font_byte;
      font_written[it.font_address] = 1'b1;
      return r;
    end
    if (!locate_row(it, addr, nbytes, subst)) return r;
    w    = eff_width();
    s    = eff_scale();
    srow = it.out_row / s;
    row  = 0;
    for (i = 0; i < nbytes; i++) row = (row << 8) | font_mem[(addr + i) % FONT_BYTES];
    // right-align the msb-first bytes to the glyph width
    row = row >> (nbytes * 8 - w);
    if (it.bold) row = row | (row >> 1);
    if (it.underline && srow == eff_height() - 1) row = 32'hffff_ffff;
    for (i = 0; i < w * s; i++) r.pixel_row[i] = row[w - 1 - i / s];
    r.row_valid   = 1'b1;
    r.substituted = subst;
    return r;
  endfunction

  function automatic in_item_t random_filler();
    logic [63:0] raw_bits;
    raw_bits = {$urandom, $urandom};
    return in_item_t'(raw_bits[$bits(in_item_t)-1:0]);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // called at a rising edge; returns at the edge that takes the beat
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    out_item_t   want;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_beat(item);
    expected_rows.push_back(want);
    beats_sent++;
    if (item.mode == MODE_WRITE) write_acks++;
    else if (!want.row_valid) rows_blank++;
  endtask

  task automatic write_font_byte(input int unsigned addr, input int unsigned value);
    in_item_t item;
    item              = random_filler();
    item.mode         = MODE_WRITE;
    item.font_address = addr[14:0];
    item.font_byte    = value[7:0];
    send_item(item);
  endtask

  // loads any font byte the row needs that was never written, then renders
  task automatic render_row(input int unsigned code, input int unsigned orow,
                            input bit bold, input bit underline);
    in_item_t    item;
    int unsigned addr;
    int unsigned nbytes;
    int unsigned i;
    bit          subst;
    item            = random_filler();
    item.mode       = MODE_RENDER;
    item.glyph_code = code[15:0];
    item.out_row    = orow[6:0];
    item.bold       = bold;
    item.underline  = underline;
    if (locate_row(item, addr, nbytes, subst)) begin
      for (i = 0; i < nbytes; i++) begin
        if (!font_written[(addr + i) % FONT_BYTES])
          write_font_byte((addr + i) % FONT_BYTES, $urandom_range(0, 255));
      end
    end
    send_item(item);
  endtask

  task automatic drain_rows();
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_GLYPH_WIDTH:  glyph_width_reg  = value[4:0];
      REG_GLYPH_HEIGHT: glyph_height_reg = value[5:0];
      REG_SCALE_FACTOR: scale_reg        = value[2:0];
      REG_GLYPH_COUNT:  glyph_count_reg  = value[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_register(input logic [1:0] idx, input string name,
                                input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got      = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) begin
      $error("%s readback mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h,
                            input int unsigned s, input int unsigned n);
    drain_rows();
    program_register(REG_GLYPH_WIDTH, w);
    program_register(REG_GLYPH_HEIGHT, h);
    program_register(REG_SCALE_FACTOR, s);
    program_register(REG_GLYPH_COUNT, n);
    check_register(REG_GLYPH_WIDTH, "glyph_width", 32'(glyph_width_reg));
    check_register(REG_GLYPH_HEIGHT, "glyph_height", 32'(glyph_height_reg));
    check_register(REG_SCALE_FACTOR, "scale_factor", 32'(scale_reg));
    check_register(REG_GLYPH_COUNT, "glyph_count", 32'(glyph_count_reg));
    settings_applied++;
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && done) begin
      if (expected_rows.size() == 0) begin
        $error("result beat with nothing outstanding: pixel_row %h row_valid %0b",
               result.pixel_row, result.row_valid);
        error_count++;
      end else begin
        want = expected_rows.pop_front();
        if (result.pixel_row !== want.pixel_row) begin
          $error("pixel_row mismatch: expected %h, actual %h",
                 want.pixel_row, result.pixel_row);
          error_count++;
        end
        if (result.row_valid !== want.row_valid) begin
          $error("row_valid mismatch: expected %0b, actual %0b",
                 want.row_valid, result.row_valid);
          error_count++;
        end
        if (result.substituted !== want.substituted) begin
          $error("substituted mismatch: expected %0b, actual %0b",
                 want.substituted, result.substituted);
          error_count++;
        end
        if (want.row_valid) rows_rendered++;
        if (want.substituted) rows_substituted++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d rows outstanding",
               idle_cycles, expected_rows.size());
      $display("[bitmap_glyph_row_scaler] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_reset_defaults();
    check_register(REG_GLYPH_WIDTH, "glyph_width", 32'(RST_GLYPH_WIDTH));
    check_register(REG_GLYPH_HEIGHT, "glyph_height", 32'(RST_GLYPH_HEIGHT));
    check_register(REG_SCALE_FACTOR, "scale_factor", 32'(RST_SCALE_FACTOR));
    check_register(REG_GLYPH_COUNT, "glyph_count", 32'(RST_GLYPH_COUNT));
  endtask

  task automatic test_write_beats();
    write_font_byte(15'h7fff, 8'h00);
    write_font_byte(15'h0000, 8'hff);
    write_font_byte(15'h5555, 8'haa);
    write_font_byte(15'h2aaa, 8'h55);
  endtask

  // reset geometry: 8 x 16 glyphs, no scaling, 256 codes
  task automatic test_default_rows();
    write_font_byte(0, 8'h81);
    render_row(0, 0, 1'b0, 1'b0);
    render_row(0, 0, 1'b1, 1'b0);
    render_row(255, 15, 1'b0, 1'b1);
    render_row(255, 14, 1'b0, 1'b1);
    render_row(256, 3, 1'b0, 1'b0);
    render_row(16'hffff, 15, 1'b1, 1'b1);
    render_row(0, 16, 1'b0, 1'b0);
    render_row(0, 127, 1'b1, 1'b1);
  endtask

  // two bytes per row, 4x scaling fills all 64 pixel columns
  task automatic test_wide_glyphs();
    set_config(16, 32, 4, 512);
    write_font_byte(0, 8'h80);
    write_font_byte(1, 8'h01);
    render_row(0, 0, 1'b0, 1'b0);
    render_row(0, 3, 1'b1, 1'b0);
    render_row(511, 127, 1'b1, 1'b0);
    render_row(511, 127, 1'b0, 1'b1);
    render_row(0, 124, 1'b0, 1'b1);
    render_row(512, 0, 1'b0, 1'b0);
  endtask

  task automatic test_register_saturation();
    set_config(0, 0, 0, 0);
    render_row(0, 0, 1'b0, 1'b0);
    render_row(0, 0, 1'b0, 1'b1);
    render_row(1, 0, 1'b1, 1'b0);
    render_row(0, 1, 1'b0, 1'b0);
    set_config(31, 63, 7, 1023);
    render_row(600, 127, 1'b0, 1'b0);
    render_row(511, 126, 1'b1, 1'b0);
    render_row(0, 0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned sel;
    int unsigned code;
    int unsigned orow;
    int unsigned n;
    int unsigned h;
    int unsigned s;
    int unsigned bpr;
    bit          paused;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_config(RST_GLYPH_WIDTH, RST_GLYPH_HEIGHT, RST_SCALE_FACTOR, RST_GLYPH_COUNT);
        1: set_config(16, 32, 4, 512);
        2: set_config(1, 1, 1, 1);
        3: set_config(9, 7, 3, 100);
        default: begin
          if ($urandom_range(0, 4) == 0)
            set_config($urandom_range(0, 31), $urandom_range(0, 63),
                       $urandom_range(0, 7), $urandom_range(0, 1023));
          else
            set_config($urandom_range(1, 16), $urandom_range(1, 32),
                       $urandom_range(1, 4), $urandom_range(1, 512));
        end
      endcase
      n      = eff_count();
      h      = eff_height();
      s      = eff_scale();
      bpr    = (eff_width() + 7) / 8;
      goal   = beats_sent + PHASE_BEATS;
      paused = 1'b0;
      while (beats_sent < goal) begin
        if ($urandom_range(0, 39) == 0) no_gaps = ($urandom_range(0, 2) == 0);
        // hold the sender until the pipeline has emptied
        if ((!paused && beats_sent + PHASE_BEATS / 2 >= goal) || $urandom_range(0, 149) == 0) begin
          drain_rows();
          paused = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          sel = $urandom_range(0, 99);
          if (sel < 75) code = $urandom_range(0, n - 1);
          else if (sel < 85) code = $urandom_range(n, n + 3);
          else code = $urandom_range(0, 65535);
          sel = $urandom_range(0, 99);
          if (sel < 70) orow = $urandom_range(0, h * s - 1);
          else if (sel < 85) orow = $urandom_range((h - 1) * s, h * s - 1);
          else orow = $urandom_range(0, 127);
          render_row(code, orow, $urandom_range(0, 1), $urandom_range(0, 1));
        end else if (sel < 88) begin
          // rewrite a byte inside a glyph that renders can reach
          code = ($urandom_range(0, 9) == 0) ? QUESTION_GLYPH : $urandom_range(0, n - 1);
          write_font_byte(code * h * bpr + $urandom_range(0, h * bpr - 1),
                          $urandom_range(0, 255));
        end else begin
          write_font_byte($urandom_range(0, FONT_BYTES - 1), $urandom_range(0, 255));
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_write_beats();
    test_default_rows();
    test_wide_glyphs();
    test_register_saturation();
    test_random_traffic();
    drain_rows();
    $display("%0d beats checked: %0d font writes, %0d rendered rows, %0d substituted, %0d blank",
             beats_sent, write_acks, rows_rendered, rows_substituted, rows_blank);
    $display("%0d register settings applied, saturated values among them", settings_applied);
    if (error_count == 0 && expected_rows.size() == 0) begin
      $display("[bitmap_glyph_row_scaler] OK");
    end else begin
      $display("[bitmap_glyph_row_scaler] ERROR");
    end
    $finish;
  end

endmodule

// ----- bitmap_glyph_row_scaler.f -----
src/bgrs_pkg.sv
src/bgrs_ram.sv
src/bgrs_addr.sv
src/bgrs_row.sv
src/bitmap_glyph_row_scaler.sv
tb/tb_bitmap_glyph_row_scaler.sv
